// ----- sv/urmp_pkg.sv -----
// Package for the UECP radiotext/RT+/Rass decoder.
// Holds shared constants, result kinds, the queue record and helper functions.
package urmp_pkg;

  localparam int MessageDepthDefault = 64;
  localparam logic [6:0] MaxTextReset = 7'd65;
  localparam logic [7:0] TextLenCap = 8'd65;

  localparam logic [7:0] ByteStart  = 8'hFE;
  localparam logic [7:0] ByteStuff  = 8'hFD;
  localparam logic [7:0] MecText    = 8'h0A;
  localparam logic [7:0] MecRtPlus  = 8'h46;
  localparam logic [7:0] MecRass    = 8'hDA;

  localparam logic [2:0] KindTextChar  = 3'd0;
  localparam logic [2:0] KindTextCrc   = 3'd1;
  localparam logic [2:0] KindRtPlus    = 3'd2;
  localparam logic [2:0] KindRassByte  = 3'd3;
  localparam logic [2:0] KindRassOk    = 3'd4;
  localparam logic [2:0] KindRassDone  = 3'd5;
  localparam logic [2:0] KindRassSeq   = 3'd6;
  localparam logic [2:0] KindRassCrc   = 3'd7;

  // Front-to-back command: a destuffed byte and what kind of position it holds.
  typedef enum logic [1:0] {
    CmdStore,     // store a text character
    CmdTextEnd,   // text frame finished, CRC result attached
    CmdDirect     // a single ready result
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic        crc_ok;
    logic [6:0]  windex;
    logic [7:0]  data;
    logic [2:0]  kind;
    logic        last;
    logic [31:0] tags;
    logic [7:0]  b4;
    logic [23:0] pnum;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  char_code;
    logic [5:0]  char_index;
    logic        last;
    logic [5:0]  tag1_type;
    logic [5:0]  tag1_start;
    logic [5:0]  tag1_len;
    logic [5:0]  tag2_type;
    logic [5:0]  tag2_start;
    logic [4:0]  tag2_len;
    logic [23:0] packet_number;
  } result_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] c);
    logic [15:0] x;
    x = {crc[7:0], crc[15:8]} ^ {8'd0, c};
    x = x ^ {12'd0, x[7:4]};
    x = x ^ {x[3:0], 12'd0} ^ {3'd0, x[7:0], 5'd0};
    return x;
  endfunction

  function automatic logic [7:0] to_latin1(input logic [7:0] c);
    logic [7:0] r;
    if (!c[7]) r = c;
    else begin
      unique case (c)
        8'h8D: r = 8'hDF;
        8'h91: r = 8'hE4;
        8'hD1: r = 8'hC4;
        8'h97: r = 8'hF6;
        8'hD7: r = 8'hD6;
        8'h99: r = 8'hFC;
        8'hD9: r = 8'hDC;
        default: r = 8'h20;
      endcase
    end
    return r;
  endfunction

endpackage

// ----- sv/urmp_if.sv -----
// Valid/ready channel interfaces for the decoder.
// Depends on urmp_pkg for no types; payload widths follow the field list.
interface urmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface urmp_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] max_text_length;
  modport source (output valid, output max_text_length, input ready);
  modport sink (input valid, input max_text_length, output ready);
endinterface

interface urmp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  char_code;
  logic [5:0]  char_index;
  logic        last;
  logic [5:0]  tag1_type;
  logic [5:0]  tag1_start;
  logic [5:0]  tag1_len;
  logic [5:0]  tag2_type;
  logic [5:0]  tag2_start;
  logic [4:0]  tag2_len;
  logic [23:0] packet_number;
  modport source (output valid, output kind, output char_code, output char_index,
                  output last, output tag1_type, output tag1_start, output tag1_len,
                  output tag2_type, output tag2_start, output tag2_len,
                  output packet_number, input ready);
  modport sink (input valid, input kind, input char_code, input char_index,
                input last, input tag1_type, input tag1_start, input tag1_len,
                input tag2_type, input tag2_start, input tag2_len,
                input packet_number, output ready);
endinterface

// ----- sv/urmp_front.sv -----
// Front end: destuffing, frame state machine, CRC and Rass sequence tracking.
// Depends on urmp_pkg; emits cmd_t records toward the command queue.
module urmp_front
  import urmp_pkg::*;
#(
  parameter int MESSAGE_DEPTH = MessageDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic [6:0] max_len,
  output logic       cmd_valid,
  input  logic       cmd_space,
  output cmd_t       cmd
);

  logic [5:0]  st;
  logic        stuff;
  logic [15:0] crc;
  logic [15:0] crc_rx;
  logic [7:0]  linfo;
  logic [7:0]  remain;
  logic [6:0]  windex;
  logic [31:0] tags;
  logic [23:0] ptotal;
  logic [23:0] cur_pkt;
  logic [24:0] expected;

  logic       take;
  logic [7:0] c;
  logic       raw_stuff;
  logic [15:0] crc_base;
  logic [15:0] crc_new;
  logic [15:0] crc_full;
  logic       crc_good;
  logic [24:0] exp_eff;
  logic [8:0] len_plus4;

  // One item is taken only when the queue has room for its possible command.
  assign in_ready = cmd_space;
  assign take     = in_valid && in_ready;
  assign raw_stuff = !stuff && (in_byte == ByteStuff);

  always_comb begin
    c = in_byte;
    if (stuff) begin
      unique case (in_byte)
        8'h00: c = 8'hFD;
        8'h01: c = 8'hFE;
        8'h02: c = 8'hFF;
        default: c = in_byte;
      endcase
    end
  end

  assign crc_base = (st == 6'd1) ? 16'hFFFF : crc;
  assign crc_new  = ((st >= 6'd1 && st < 6'd11) || (st >= 6'd26 && st < 6'd36))
                    ? crc_step(crc_base, c) : crc_base;
  assign crc_full = {crc_rx[15:8], c};
  assign crc_good = (crc_full == ~crc);
  assign exp_eff  = (expected == 25'd0) ? 25'd1 : expected;
  assign len_plus4 = {1'b0, c} + 9'd4;

  always_comb begin
    cmd_valid = 1'b0;
    cmd = '0;
    cmd.op = CmdDirect;
    cmd.data = c;
    cmd.windex = windex;
    cmd.tags = tags;
    cmd.b4 = c;
    cmd.pnum = cur_pkt;
    cmd.last = 1'b1;
    if (take && !raw_stuff) begin
      unique case (st)
        6'd10: begin
          cmd_valid = 1'b1;
          cmd.op = CmdStore;
        end
        6'd12: begin
          cmd_valid = 1'b1;
          cmd.op = CmdTextEnd;
          cmd.crc_ok = crc_good;
        end
        6'd35: begin
          cmd_valid = 1'b1;
          cmd.kind = KindRassByte;
          cmd.last = (remain == 8'd0);
        end
        6'd37: begin
          cmd_valid = 1'b1;
          if (!crc_good) cmd.kind = KindRassCrc;
          else if (exp_eff != {1'b0, cur_pkt}) cmd.kind = KindRassSeq;
          else if (cur_pkt == ptotal) cmd.kind = KindRassDone;
          else cmd.kind = KindRassOk;
        end
        6'd46: begin
          // The back end drops the tags if no text has been shown by then.
          cmd_valid = 1'b1;
          cmd.kind = KindRtPlus;
        end
        default: cmd_valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= 6'd0;
      stuff <= 1'b0;
      crc <= 16'hFFFF;
      crc_rx <= '0;
      linfo <= '0;
      remain <= '0;
      windex <= '0;
      tags <= '0;
      ptotal <= '0;
      cur_pkt <= '0;
      expected <= '0;
    end else if (take) begin
      if (raw_stuff) begin
        stuff <= 1'b1;
      end else begin
        stuff <= 1'b0;
        crc <= crc_new;
        unique case (st)
          6'd0: if (c == ByteStart) st <= 6'd1;
          6'd1, 6'd2, 6'd3, 6'd6, 6'd7, 6'd9, 6'd27, 6'd28, 6'd39, 6'd40, 6'd41:
            st <= st + 6'd1;
          6'd4: begin
            linfo <= c;
            st <= 6'd5;
          end
          6'd5: begin
            priority if (c == MecText) st <= 6'd6;
            else if (c == MecRtPlus) st <= 6'd38;
            else if (c == MecRass) st <= 6'd26;
            else st <= 6'd0;
          end
          6'd8: begin
            if (c < 8'd2 || c > TextLenCap || {1'b0, c} > 9'(MESSAGE_DEPTH + 1) ||
                c > {1'b0, max_len} || len_plus4 > {1'b0, linfo}) begin
              st <= 6'd0;
            end else begin
              remain <= c - 8'd2;
              windex <= '0;
              st <= 6'd9;
            end
          end
          6'd10: begin
            windex <= windex + 7'd1;
            if (remain != 8'd0) remain <= remain - 8'd1;
            else st <= 6'd11;
          end
          6'd11, 6'd36: begin
            crc_rx <= {c, 8'd0};
            st <= st + 6'd1;
          end
          6'd12: st <= 6'd0;
          6'd26: begin
            if (c < 8'd9) st <= 6'd0;
            else begin
              remain <= c - 8'd9;
              linfo <= c;
              windex <= '0;
              st <= 6'd27;
            end
          end
          6'd29: begin cur_pkt <= {c, 16'd0}; st <= 6'd30; end
          6'd30: begin cur_pkt[15:8] <= c; st <= 6'd31; end
          6'd31: begin cur_pkt[7:0] <= c; st <= 6'd32; end
          6'd32: begin ptotal <= {c, 16'd0}; st <= 6'd33; end
          6'd33: begin ptotal[15:8] <= c; st <= 6'd34; end
          6'd34: begin ptotal[7:0] <= c; st <= 6'd35; end
          6'd35: begin
            windex <= windex + 7'd1;
            if (remain != 8'd0) remain <= remain - 8'd1;
            else st <= 6'd36;
          end
          6'd37: begin
            st <= 6'd0;
            if (crc_good && exp_eff == {1'b0, cur_pkt} && cur_pkt != ptotal)
              expected <= exp_eff + 25'd1;
            else expected <= '0;
          end
          6'd38: begin linfo <= c; st <= 6'd39; end
          6'd42, 6'd43, 6'd44, 6'd45: begin
            tags <= {tags[23:0], c};
            st <= st + 6'd1;
          end
          default: st <= 6'd0;
        endcase
      end
    end
  end

endmodule

// ----- sv/urmp_queue.sv -----
// Short FIFO of front-end commands between the front and the back end.
// Depends on urmp_pkg for cmd_t.
module urmp_queue
  import urmp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic has_space,
  output logic not_empty,
  input  logic pop,
  output cmd_t head
);

  localparam int AW = $clog2(DEPTH);

  cmd_t        mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   count;

  assign has_space = (count < (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ----- sv/urmp_back.sv -----
// Back end: message store, trailing-space scan, text replay and result output.
// Depends on urmp_pkg for cmd_t, result kinds and the character table.
module urmp_back
  import urmp_pkg::*;
#(
  parameter int MESSAGE_DEPTH = MessageDepthDefault
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   cmd_ready_in,
  input  cmd_t   cmd_in,
  output logic   cmd_pop,
  output logic   out_valid,
  input  logic   out_ready,
  output result_t out_res
);

  localparam int AW = $clog2(MESSAGE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_RD, S_SCAN, S_FIRST, S_PLAY_RD, S_PLAY
  } bstate_t;

  bstate_t       state;
  logic [7:0]    store [MESSAGE_DEPTH];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] m_idx;
  logic [AW-1:0] p_idx;
  logic [7:0]    first_char;
  logic          out_full;
  logic          out_free;
  logic [AW:0]   cnt;
  logic          text_seen;

  assign out_free  = !out_full || out_ready;
  assign out_valid = out_full;

  // Clamp the written count to the store and to the 64-position output range.
  always_comb begin
    cnt = (AW+1)'(cmd_in.windex);
    if ({1'b0, cmd_in.windex} > 8'(MESSAGE_DEPTH)) cnt = (AW+1)'(MESSAGE_DEPTH);
    if (cnt > (AW+1)'(64)) cnt = (AW+1)'(64);
    if (cnt == '0) cnt = (AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd_ready_in && state == S_IDLE && cmd_in.op == CmdStore &&
        {1'b0, cmd_in.windex} < 8'(MESSAGE_DEPTH))
      store[cmd_in.windex[AW-1:0]] <= to_latin1(cmd_in.data);
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
      text_seen <= 1'b0;
      cmd_pop <= 1'b0;
      rd_addr <= '0;
      m_idx <= '0;
      p_idx <= '0;
      first_char <= '0;
      out_res <= '0;
    end else begin
      cmd_pop <= 1'b0;
      if (out_full && out_ready) out_full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_ready_in && !cmd_pop) begin
            unique case (cmd_in.op)
              CmdStore: cmd_pop <= 1'b1;
              CmdTextEnd: begin
                if (!cmd_in.crc_ok) begin
                  if (out_free) begin
                    out_res <= '0;
                    out_res.kind <= KindTextCrc;
                    out_res.last <= 1'b1;
                    out_full <= 1'b1;
                    cmd_pop <= 1'b1;
                  end
                end else begin
                  m_idx <= AW'(cnt - 1'b1);
                  rd_addr <= AW'(cnt - 1'b1);
                  cmd_pop <= 1'b1;
                  state <= S_SCAN_RD;
                end
              end
              default: begin
                // Tags are judged here, in order behind any text still replaying.
                if (cmd_in.kind == KindRtPlus && !text_seen) begin
                  cmd_pop <= 1'b1;
                end else if (out_free) begin
                  out_res <= '0;
                  out_res.kind <= cmd_in.kind;
                  out_res.last <= cmd_in.last;
                  out_res.packet_number <= cmd_in.pnum;
                  if (cmd_in.kind == KindRassByte) begin
                    out_res.char_code <= cmd_in.data;
                    out_res.char_index <= cmd_in.windex[5:0];
                  end
                  if (cmd_in.kind == KindRtPlus) begin
                    out_res.packet_number <= '0;
                    out_res.tag1_type <= {cmd_in.tags[26:24], cmd_in.tags[23:21]};
                    out_res.tag1_start <= {cmd_in.tags[20:16], cmd_in.tags[15]};
                    out_res.tag1_len <= cmd_in.tags[14:9];
                    out_res.tag2_type <= {cmd_in.tags[8], cmd_in.tags[7:3]};
                    out_res.tag2_start <= {cmd_in.tags[2:0], cmd_in.b4[7:5]};
                    out_res.tag2_len <= cmd_in.b4[4:0];
                  end
                  out_full <= 1'b1;
                  cmd_pop <= 1'b1;
                end
              end
            endcase
          end
        end
        S_SCAN_RD: state <= S_SCAN;
        S_SCAN: begin
          // Walk back over trailing spaces, one store read per pass through S_SCAN_RD and S_SCAN.
          if (m_idx != '0 && rd_data == 8'h20) begin
            m_idx <= m_idx - 1'b1;
            rd_addr <= m_idx - 1'b1;
            state <= S_SCAN_RD;
          end else begin
            rd_addr <= '0;
            p_idx <= '0;
            state <= S_FIRST;
          end
        end
        S_FIRST: state <= S_PLAY;
        S_PLAY_RD: state <= S_PLAY;
        S_PLAY: begin
          if (out_free) begin
            out_res <= '0;
            out_res.kind <= KindTextChar;
            out_res.char_code <= rd_data;
            out_res.char_index <= 6'(p_idx);
            out_res.last <= (p_idx == m_idx);
            out_full <= 1'b1;
            if (p_idx == '0) first_char <= rd_data;
            if (p_idx == m_idx) begin
              if ((p_idx == '0) ? (rd_data != 8'd0) : (first_char != 8'd0))
                text_seen <= 1'b1;
              state <= S_IDLE;
            end else begin
              p_idx <= p_idx + 1'b1;
              rd_addr <= p_idx + 1'b1;
              state <= S_PLAY_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_last_on_status: assert property (@(posedge clk) disable iff (rst)
    out_full && out_res.kind != KindTextChar && out_res.kind != KindRassByte
    |-> out_res.last) else $error("status result without last");
  a_pop_once: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> !cmd_pop) else $error("double pop");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    state == S_PLAY && out_free && p_idx == m_idx |=> state == S_IDLE)
    else $error("replay did not end");

endmodule

// ----- sv/uecp_rds_message_parser.sv -----
// Top level of the UECP radiotext / RT+ / Rass decoder.
// Depends on urmp_pkg, the channel interfaces and the front, queue and back modules.
// Latency: a result that one byte completes passes, when the back end is idle, through
// the command queue and the back end's output register; a good text frame is first
// scanned backward over trailing spaces, then replayed one character per S_PLAY_RD and
// S_PLAY pass. Throughput: one byte per cycle into the four-entry command queue while
// it has space; the back end registers each pop and takes no new command while a pop
// is pending. Reset (rst, synchronous) empties the queue and returns to waiting for a
// start byte; the message store is not cleared.
module uecp_rds_message_parser
  import urmp_pkg::*;
#(
  parameter int MESSAGE_DEPTH = MessageDepthDefault
) (
  input logic clk,
  input logic rst,
  urmp_in_if.sink    in_ch,
  urmp_cfg_if.sink   cfg,
  urmp_out_if.source out_ch
);

  logic [6:0] max_len;
  logic       cmd_valid;
  logic       q_space;
  logic       q_nempty;
  logic       q_pop;
  cmd_t       cmd;
  cmd_t       head;
  result_t    res;

  // The configuration register is always writable.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) max_len <= MaxTextReset;
    else if (cfg.valid) max_len <= cfg.max_text_length;
  end

  urmp_front #(.MESSAGE_DEPTH(MESSAGE_DEPTH)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_byte(in_ch.data_byte),
    .max_len, .cmd_valid, .cmd_space(q_space), .cmd
  );

  urmp_queue #(.DEPTH(4)) u_queue (
    .clk, .rst, .push(cmd_valid), .push_data(cmd), .has_space(q_space),
    .not_empty(q_nempty), .pop(q_pop), .head
  );

  urmp_back #(.MESSAGE_DEPTH(MESSAGE_DEPTH)) u_back (
    .clk, .rst, .cmd_ready_in(q_nempty), .cmd_in(head), .cmd_pop(q_pop),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );

  assign out_ch.kind = res.kind;
  assign out_ch.char_code = res.char_code;
  assign out_ch.char_index = res.char_index;
  assign out_ch.last = res.last;
  assign out_ch.tag1_type = res.tag1_type;
  assign out_ch.tag1_start = res.tag1_start;
  assign out_ch.tag1_len = res.tag1_len;
  assign out_ch.tag2_type = res.tag2_type;
  assign out_ch.tag2_start = res.tag2_start;
  assign out_ch.tag2_len = res.tag2_len;
  assign out_ch.packet_number = res.packet_number;

endmodule
